>>> hdl/gfba_pkg.sv
// gfba_pkg: shared codes and control/status bundles for the grouped free block allocator
// used by gfba_ctrl, gfba_dp, the top level and the port checker; no dependencies
package gfba_pkg;

  // input word commands
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_REFILL = 2'd2;
  localparam logic [1:0] CMD_SYNC   = 2'd3;

  // result word kinds
  localparam logic [2:0] KIND_GRANT       = 3'd0;
  localparam logic [2:0] KIND_GRANT_FETCH = 3'd1;
  localparam logic [2:0] KIND_EXHAUSTED   = 3'd2;
  localparam logic [2:0] KIND_FREED       = 3'd3;
  localparam logic [2:0] KIND_SPILL       = 3'd4;
  localparam logic [2:0] KIND_REFILL      = 3'd5;
  localparam logic [2:0] KIND_BUSY        = 3'd6;
  localparam logic [2:0] KIND_SYNC        = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic latch;        // capture the accepted input word
    logic mark;         // place the end-of-chain marker at the bottom
    logic spill_start;  // begin spilling a full stack
    logic spill_emit;   // send one spill word
    logic exec;         // run a single-result command
    logic spill_addr;   // read port follows the spill pointer
  } gfba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;    // output register can take a word this cycle
    logic silent;       // refill word with no refill pending
    logic mark;         // free onto an empty stack
    logic spill;        // free onto a full stack
    logic spill_last;   // spill pointer at the final word
  } gfba_sts_t;

endpackage

>>> hdl/gfba_ctrl.sv
// gfba_ctrl: sequencing state machine for the grouped free block allocator
// depends on gfba_pkg
module gfba_ctrl import gfba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  gfba_sts_t sts,
  output gfba_cmd_t ctl
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_EXEC     = 2'd1;
  localparam logic [1:0] ST_SPILL_EM = 2'd2;
  localparam logic [1:0] ST_SPILL_RD = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.mark) begin
          ctl.mark = 1'b1;
        end else if (sts.silent) begin
          state_nxt = ST_IDLE;
        end else if (sts.spill) begin
          ctl.spill_start = 1'b1;
          state_nxt       = ST_SPILL_EM;
        end else if (sts.slot_free) begin
          ctl.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SPILL_EM: begin
        ctl.spill_addr = 1'b1;
        if (sts.slot_free) begin
          ctl.spill_emit = 1'b1;
          state_nxt      = sts.spill_last ? ST_IDLE : ST_SPILL_RD;
        end
      end
      ST_SPILL_RD: begin
        ctl.spill_addr = 1'b1;
        state_nxt      = ST_SPILL_EM;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/gfba_dp.sv
// gfba_dp: free stack memory, count and refill registers, output register
// depends on gfba_pkg; driven by gfba_ctrl
module gfba_dp import gfba_pkg::*; #(
  parameter int GROUP_SIZE = 32,
  parameter int BLOCK_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gfba_cmd_t                         ctl,
  output gfba_sts_t                         sts,
  input  logic [1:0]                        in_cmd,
  input  logic [BLOCK_BITS-1:0]             in_block_number,
  input  logic [BLOCK_BITS-1:0]             in_group_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_kind,
  output logic [BLOCK_BITS-1:0]             out_result_block,
  output logic [BLOCK_BITS-1:0]             out_word_value,
  output logic [$clog2(GROUP_SIZE+1)-1:0]   out_word_index,
  output logic                              out_last,
  output logic                              out_modified
);

  localparam int IW = $clog2(GROUP_SIZE + 1);
  localparam int AW = $clog2(GROUP_SIZE);
  localparam logic [IW-1:0]         GS     = IW'(GROUP_SIZE);
  localparam logic [BLOCK_BITS-1:0] GS_BLK = BLOCK_BITS'(GROUP_SIZE);

  logic [BLOCK_BITS-1:0] mem [GROUP_SIZE];
  logic [BLOCK_BITS-1:0] rd_data_r;
  logic [AW-1:0]         rd_addr;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [BLOCK_BITS-1:0] wd;

  logic [1:0]            cmd_r;
  logic [BLOCK_BITS-1:0] blk_r, word_r;
  logic [IW-1:0]         count_r, count_nxt;
  logic                  mod_r, mod_nxt;
  logic                  ract_r, ract_nxt;
  logic [IW-1:0]         ridx_r, ridx_nxt;
  logic [IW-1:0]         sidx_r, sidx_nxt;
  logic [IW-1:0]         count_dec;
  logic [BLOCK_BITS-1:0] refill_val;

  logic                  ld;
  logic                  out_valid_r;
  logic [2:0]            kind_r, kind_nxt;
  logic [BLOCK_BITS-1:0] rblk_r, rblk_nxt;
  logic [BLOCK_BITS-1:0] wval_r, wval_nxt;
  logic [IW-1:0]         widx_r, widx_nxt;
  logic                  last_r, last_nxt;
  logic                  omod_r, omod_nxt;

  assign count_dec = count_r - IW'(1);
  assign rd_addr   = ctl.spill_addr ? AW'(sidx_r - IW'(1)) : AW'(count_dec);

  // status towards the controller
  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.silent     = (cmd_r == CMD_REFILL) && !ract_r;
  assign sts.mark       = (cmd_r == CMD_FREE) && !ract_r && (count_r == '0);
  assign sts.spill      = (cmd_r == CMD_FREE) && !ract_r && (count_r == GS);
  assign sts.spill_last = (sidx_r == GS);

  // count word of a refill saturates at the group size
  assign refill_val = (ridx_r != '0) ? word_r :
                      ((word_r > GS_BLK) ? GS_BLK : word_r);

  always_comb begin
    count_nxt = count_r;
    mod_nxt   = mod_r;
    ract_nxt  = ract_r;
    ridx_nxt  = ridx_r;
    sidx_nxt  = sidx_r;
    we        = 1'b0;
    wa        = '0;
    wd        = '0;
    ld        = 1'b0;
    kind_nxt  = kind_r;
    rblk_nxt  = rblk_r;
    wval_nxt  = wval_r;
    widx_nxt  = widx_r;
    last_nxt  = last_r;
    omod_nxt  = omod_r;

    if (ctl.mark) begin
      we        = 1'b1;
      count_nxt = IW'(1);
    end

    if (ctl.spill_start) begin
      mod_nxt  = 1'b1;
      sidx_nxt = '0;
    end

    if (ctl.spill_emit) begin
      ld       = 1'b1;
      kind_nxt = KIND_SPILL;
      rblk_nxt = blk_r;
      wval_nxt = (sidx_r == '0) ? BLOCK_BITS'(count_r) : rd_data_r;
      widx_nxt = sidx_r;
      last_nxt = sts.spill_last;
      omod_nxt = mod_r;
      sidx_nxt = sidx_r + IW'(1);
      if (sts.spill_last) begin
        // freed block becomes the new bottom entry
        we        = 1'b1;
        wd        = blk_r;
        count_nxt = IW'(1);
      end
    end

    if (ctl.exec) begin
      ld       = 1'b1;
      kind_nxt = KIND_BUSY;
      rblk_nxt = '0;
      wval_nxt = '0;
      widx_nxt = '0;
      last_nxt = 1'b1;
      unique case (cmd_r) inside
        CMD_SYNC: begin
          kind_nxt = KIND_SYNC;
          mod_nxt  = 1'b0;
        end
        CMD_REFILL: begin
          kind_nxt = KIND_REFILL;
          wval_nxt = refill_val;
          widx_nxt = ridx_r;
          if (ridx_r == '0) begin
            count_nxt = IW'(refill_val);
          end else begin
            we = 1'b1;
            wa = AW'(ridx_r - IW'(1));
            wd = word_r;
          end
          if (ridx_r == GS) begin
            ract_nxt = 1'b0;
            ridx_nxt = '0;
          end else begin
            ridx_nxt = ridx_r + IW'(1);
          end
        end
        CMD_ALLOC, CMD_FREE: begin
          if (ract_r) begin
            kind_nxt = KIND_BUSY;
          end else if (cmd_r == CMD_FREE) begin
            we        = 1'b1;
            wa        = AW'(count_r);
            wd        = blk_r;
            count_nxt = count_r + IW'(1);
            mod_nxt   = 1'b1;
            kind_nxt  = KIND_FREED;
            rblk_nxt  = blk_r;
          end else if (count_r == '0 || rd_data_r == '0) begin
            count_nxt = '0;
            kind_nxt  = KIND_EXHAUSTED;
          end else begin
            count_nxt = count_dec;
            mod_nxt   = 1'b1;
            rblk_nxt  = rd_data_r;
            if (count_dec == '0) begin
              // last entry names the block holding the next group
              ract_nxt = 1'b1;
              ridx_nxt = '0;
              kind_nxt = KIND_GRANT_FETCH;
            end else begin
              kind_nxt = KIND_GRANT;
            end
          end
        end
        default: kind_nxt = KIND_BUSY;
      endcase
      omod_nxt = (cmd_r == CMD_SYNC) ? mod_r : mod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r  <= in_cmd;
      blk_r  <= in_block_number;
      word_r <= in_group_word;
    end
    sidx_r <= sidx_nxt;
    kind_r <= kind_nxt;
    rblk_r <= rblk_nxt;
    wval_r <= wval_nxt;
    widx_r <= widx_nxt;
    last_r <= last_nxt;
    omod_r <= omod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      mod_r       <= 1'b0;
      ract_r      <= 1'b0;
      ridx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      mod_r   <= mod_nxt;
      ract_r  <= ract_nxt;
      ridx_r  <= ridx_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_result_block = rblk_r;
  assign out_word_value   = wval_r;
  assign out_word_index   = widx_r;
  assign out_last         = last_r;
  assign out_modified     = omod_r;

endmodule

>>> hdl/grouped_free_block_allocator_unit.sv
// grouped_free_block_allocator_unit: top level of the grouped free block allocator
// instantiates gfba_ctrl and gfba_dp; depends on gfba_pkg
//
// usage
// - input channel (in_valid/in_ready): one word per command: alloc, free of
//   in_block_number, refill word in_group_word, or sync query
// - result channel (out_valid/out_ready): one result word per command, a
//   refill word with no refill pending gives none, a free onto a full stack
//   gives GROUP_SIZE+1 spill words (count first, then the entries) with
//   out_last on the final one
// - sequencing: the accepted word is latched and the controller enters EXEC,
//   which loads the result into the output register once it is free; a free
//   onto an empty stack first lays down the end-of-chain marker there, and a
//   spill goes on to SPILL_EM, which loads the count word first
// - a spill alternates SPILL_EM, which sends one word, and SPILL_RD, which the
//   single registered read port of the stack memory needs
// - the block takes one command at a time; in_ready is high only while idle
// - a stalled receiver holds the output register and the command in flight
//   waits; nothing is lost or repeated
// - reset empties the stack count and clears the modified and refill state;
//   stack entries hold no reset value and are only read once written
module grouped_free_block_allocator_unit import gfba_pkg::*; #(
  parameter int GROUP_SIZE = 32,
  parameter int BLOCK_BITS = 15
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_cmd,
  input  logic [BLOCK_BITS-1:0]           in_block_number,
  input  logic [BLOCK_BITS-1:0]           in_group_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_kind,
  output logic [BLOCK_BITS-1:0]           out_result_block,
  output logic [BLOCK_BITS-1:0]           out_word_value,
  output logic [$clog2(GROUP_SIZE+1)-1:0] out_word_index,
  output logic                            out_last,
  output logic                            out_modified
);

  gfba_cmd_t ctl;  // sequencing commands to the datapath
  gfba_sts_t sts;  // datapath conditions back to the controller

  gfba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  gfba_dp #(
    .GROUP_SIZE (GROUP_SIZE),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_block_number  (in_block_number),
    .in_group_word    (in_group_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_result_block (out_result_block),
    .out_word_value   (out_word_value),
    .out_word_index   (out_word_index),
    .out_last         (out_last),
    .out_modified     (out_modified)
  );

endmodule

>>> hdl/gfba_checker.sv
// gfba_checker: port-level checks on the grouped free block allocator, with its bind
// depends on gfba_pkg; attaches to grouped_free_block_allocator_unit
module gfba_checker import gfba_pkg::*; #(
  parameter int GROUP_SIZE = 32,
  parameter int BLOCK_BITS = 15
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2:0]                      out_kind,
  input logic [BLOCK_BITS-1:0]           out_word_value,
  input logic [$clog2(GROUP_SIZE+1)-1:0] out_word_index,
  input logic                            out_last
);

  localparam int IW = $clog2(GROUP_SIZE + 1);

  // a waiting result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_value) && $stable(out_kind))
    else $error("result word changed while stalled");

  // one command at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a spill ends exactly on its final entry
  a_spill_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SPILL |-> out_last == (out_word_index == IW'(GROUP_SIZE)))
    else $error("spill last flag misplaced");

  // every other kind is a single-word result
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_SPILL |-> out_last)
    else $error("single result without last");

endmodule

bind grouped_free_block_allocator_unit gfba_checker #(
  .GROUP_SIZE (GROUP_SIZE),
  .BLOCK_BITS (BLOCK_BITS)
) u_gfba_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_word_value (out_word_value),
  .out_word_index (out_word_index),
  .out_last       (out_last)
);

>>> tb/grouped_free_block_allocator_unit_tb.sv
// grouped_free_block_allocator_unit_tb: self-checking bench for the grouped free block allocator
// drives alloc, free, refill and sync words and checks each result word against its own free-list
// model; depends on gfba_pkg and grouped_free_block_allocator_unit
module grouped_free_block_allocator_unit_tb;
  import gfba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GS          = 32;                // stack depth of the block under test
  localparam int BW          = 15;                // block number width
  localparam int IW          = $clog2(GS + 1);    // spill/refill position width
  localparam int ITEMS       = 230;               // rough length of the random part
  localparam int STALL_LIMIT = 2000;              // cycles with no word moving before giving up

  // one result word, laid out in port order
  typedef struct packed {
    logic [2:0]    kind;
    logic [BW-1:0] blk;
    logic [BW-1:0] value;
    logic [IW-1:0] pos;
    logic          last;
    logic          modified;
  } alloc_result_t;

  // free list bookkeeping: mirrors the stack, count, modified flag and refill state,
  // and keeps the result words still owed by the block
  class free_list_book;
    alloc_result_t owed[$];
    logic [BW-1:0] blocks [GS];
    int            depth;
    int            fill_pos;
    bit            dirty;
    bit            refilling;
    int            failures;

    function new();
      foreach (blocks[i]) blocks[i] = '0;
      depth     = 0;
      fill_pos  = 0;
      dirty     = 1'b0;
      refilling = 1'b0;
      failures  = 0;
    endfunction

    function void owe(logic [2:0] kind, logic [BW-1:0] blk, logic [BW-1:0] value, int pos,
                      bit last);
      alloc_result_t r;
      r.kind     = kind;
      r.blk      = blk;
      r.value    = value;
      r.pos      = IW'(pos);
      r.last     = last;
      r.modified = dirty;
      owed.push_back(r);
    endfunction

    // update the model for one accepted word and queue the results it causes
    function void note_command(logic [1:0] c, logic [BW-1:0] b, logic [BW-1:0] w);
      logic [BW-1:0] v;
      int            i;
      case (c)
        CMD_SYNC: begin
          owe(KIND_SYNC, '0, '0, 0, 1'b1);
          dirty = 1'b0;
        end
        CMD_REFILL: begin
          // silently dropped unless a group fetch is pending
          if (refilling) begin
            if (fill_pos == 0) begin
              v     = (w > GS) ? BW'(GS) : w;
              depth = int'(v);
            end else begin
              v                   = w;
              blocks[fill_pos - 1] = w;
            end
            owe(KIND_REFILL, '0, v, fill_pos, 1'b1);
            fill_pos++;
            if (fill_pos >= GS + 1) begin
              refilling = 1'b0;
              fill_pos  = 0;
            end
          end
        end
        default: begin
          if (refilling) begin
            owe(KIND_BUSY, '0, '0, 0, 1'b1);
          end else if (c == CMD_ALLOC) begin
            if (depth == 0) begin
              owe(KIND_EXHAUSTED, '0, '0, 0, 1'b1);
            end else begin
              depth--;
              v = blocks[depth];
              if (v == '0) begin
                // end of chain reached
                depth = 0;
                owe(KIND_EXHAUSTED, '0, '0, 0, 1'b1);
              end else begin
                dirty = 1'b1;
                if (depth == 0) begin
                  refilling = 1'b1;
                  fill_pos  = 0;
                  owe(KIND_GRANT_FETCH, v, '0, 0, 1'b1);
                end else begin
                  owe(KIND_GRANT, v, '0, 0, 1'b1);
                end
              end
            end
          end else begin
            dirty = 1'b1;
            if (depth == 0) begin
              depth     = 1;
              blocks[0] = '0;
            end
            if (depth >= GS) begin
              // full stack goes out into the freed block, count first
              owe(KIND_SPILL, b, BW'(depth), 0, 1'b0);
              for (i = 0; i < GS; i++) owe(KIND_SPILL, b, blocks[i], i + 1, i == GS - 1);
              blocks[0] = b;
              depth     = 1;
            end else begin
              blocks[depth] = b;
              depth++;
              owe(KIND_FREED, b, '0, 0, 1'b1);
            end
          end
        end
      endcase
    endfunction

    function string show(alloc_result_t r);
      return $sformatf("kind %0d block %0d value %0d index %0d last %0b mod %0b",
                       r.kind, r.blk, r.value, r.pos, r.last, r.modified);
    endfunction

    function void complain(string what);
      failures++;
      if (failures <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (owed.size() == 0) begin
        complain({"unrequested word: ", show(got)});
        return;
      end
      want = owed.pop_front();
      if (got.kind !== want.kind || got.blk !== want.blk || got.value !== want.value ||
          got.pos !== want.pos || got.last !== want.last || got.modified !== want.modified)
        complain({"expected ", show(want), ", got ", show(got)});
    endfunction

    function void close();
      while (owed.size() != 0) complain({"never seen: ", show(owed.pop_front())});
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid;
  logic          in_ready;
  logic [1:0]    in_cmd;
  logic [BW-1:0] in_block_number;
  logic [BW-1:0] in_group_word;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [2:0]    out_kind;
  logic [BW-1:0] out_result_block;
  logic [BW-1:0] out_word_value;
  logic [IW-1:0] out_word_index;
  logic          out_last;
  logic          out_modified;

  free_list_book book;
  int            sent;                // words taken that the block acts on
  int            sender_idle_pct;
  int            receiver_idle_pct;
  int            stall_cycles;
  bit            saturated_once;      // first group count word is made too large

  grouped_free_block_allocator_unit #(
    .GROUP_SIZE(GS),
    .BLOCK_BITS(BW)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_block_number  (in_block_number),
    .in_group_word    (in_group_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_result_block (out_result_block),
    .out_word_value   (out_word_value),
    .out_word_index   (out_word_index),
    .out_last         (out_last),
    .out_modified     (out_modified)
  );

  always #6 clk = ~clk;

  // receiver: random back-pressure, changed on the falling edge only
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
  end

  // every result word taken is checked against the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      book.check_result(alloc_result_t'({out_kind, out_result_block, out_word_value,
                                         out_word_index, out_last, out_modified}));
  end

  // watchdog: a long run of cycles with no word moving on either side means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // mostly ordinary block numbers, with the end marker and all ones now and then
  function automatic logic [BW-1:0] pick_block();
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 10) return '1;
    return BW'($urandom_range(1, (1 << BW) - 1));
  endfunction

  // offer one word from a falling edge and hold it until taken; the idle
  // pattern follows how far the run has got
  task automatic send_word(input logic [1:0] c, input logic [BW-1:0] b, input logic [BW-1:0] w);
    if (sent < ITEMS / 3) begin
      sender_idle_pct   = 34;
      receiver_idle_pct = 88;
    end else if (sent < 2 * ITEMS / 3) begin
      sender_idle_pct   = 88;
      receiver_idle_pct = 34;
    end else begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= c;
    in_block_number <= b;
    in_group_word   <= w;
    do @(posedge clk); while (!in_ready);
    // a refill word with nothing pending is ignored and not counted
    if (c != CMD_REFILL || book.refilling) sent++;
    book.note_command(c, b, w);
    @(negedge clk);
  endtask

  // run of frees, either a few or until the stack spills into the freed block
  task automatic fill_run(input bit to_spill);
    int n;
    bit was_full;
    n = to_spill ? GS + 2 : $urandom_range(1, 8);
    do begin
      was_full = (book.depth >= GS);
      send_word(CMD_FREE, pick_block(), pick_block());
      n--;
      if ($urandom_range(99) < 4) send_word(CMD_SYNC, pick_block(), pick_block());
    end while (to_spill ? !was_full : n > 0);
  endtask

  // pop until the chain ends or a group fetch starts, rarely stopping early
  task automatic drain_run();
    do send_word(CMD_ALLOC, pick_block(), pick_block());
    while (book.depth > 0 && !book.refilling && $urandom_range(99) >= 2);
  endtask

  initial begin
    logic [BW-1:0] w;
    int            pick;
    book              = new();
    sent              = 0;
    sender_idle_pct   = 34;
    receiver_idle_pct = 88;
    stall_cycles      = 0;
    saturated_once    = 1'b0;
    in_valid          = 1'b0;
    in_cmd            = CMD_SYNC;
    in_block_number   = '0;
    in_group_word     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: fresh state, field extremes and the cheap corner cases
    send_word(CMD_SYNC, '1, '0);                 // nothing modified yet
    send_word(CMD_ALLOC, '0, '1);                // empty stack reports exhausted
    send_word(CMD_REFILL, '0, '1);               // no fetch pending, dropped
    send_word(CMD_FREE, '1, '0);                 // empty stack gets its end marker first
    send_word(CMD_FREE, '0, '1);                 // block zero pushed as an entry
    send_word(CMD_FREE, BW'(1), '0);
    send_word(CMD_SYNC, '0, '1);                 // modified then cleared
    send_word(CMD_SYNC, '1, '1);
    send_word(CMD_ALLOC, '1, '0);                // grant
    send_word(CMD_ALLOC, '0, '0);                // pops block zero: exhausted, count cleared
    send_word(CMD_ALLOC, '1, '1);                // empty again
    send_word(CMD_FREE, BW'(15'h2aaa), BW'(15'h5555));
    send_word(CMD_FREE, BW'(15'h5555), BW'(15'h2aaa));
    send_word(CMD_ALLOC, BW'(15'h5555), '0);
    send_word(CMD_ALLOC, '0, BW'(15'h2aaa));
    send_word(CMD_ALLOC, '0, '0);                // end marker: exhausted
    send_word(CMD_REFILL, BW'(15'h2aaa), BW'(15'h5555));

    // one full cycle up front: spill, drain to the group fetch, refill follows below
    fill_run(1'b1);
    drain_run();

    // random part: mostly well-formed runs, some stray words and broken refills
    while (sent < ITEMS) begin
      pick = $urandom_range(99);
      if (book.refilling && pick >= 15) begin
        if (book.fill_pos == 0) begin
          if (!saturated_once) begin
            w              = BW'($urandom_range(GS + 1, (1 << BW) - 1));
            saturated_once = 1'b1;
          end else begin
            case ($urandom_range(5))
              0:       w = '0;
              1:       w = BW'(1);
              2:       w = BW'(GS);
              3:       w = BW'($urandom_range(GS + 1, (1 << BW) - 1));
              default: w = BW'($urandom_range(1, GS));
            endcase
          end
        end else begin
          w = pick_block();
        end
        send_word(CMD_REFILL, pick_block(), w);
      end else if (book.refilling || pick < 25) begin
        // stray word of any kind, busy during a refill
        send_word(2'($urandom_range(3)), pick_block(), pick_block());
      end else if (pick < 55) begin
        fill_run(pick < 35);
      end else if (pick < 85) begin
        drain_run();
      end else begin
        send_word(CMD_SYNC, pick_block(), pick_block());
      end
    end
    in_valid <= 1'b0;

    // let the last words drain, then a short quiet spell for stray output
    while (book.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    book.close();
    if (book.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
